/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every enabled clock edge
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ucpd_pkg.sv */
// ----------------------------------------------------------------------------
// ucpd_pkg
// types and constants shared by the code point decoder and its channels
// ----------------------------------------------------------------------------
package ucpd_pkg;

   typedef enum logic [2:0] {
      ENC_ASCII   = 3'd0,
      ENC_UTF8    = 3'd1,
      ENC_UTF16BE = 3'd2,
      ENC_UTF16LE = 3'd3,
      ENC_UTF32BE = 3'd4,
      ENC_UTF32LE = 3'd5
   } enc_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_SEQ = 2'd1,
      ST_BAD_CP  = 2'd2,
      ST_BAD_ENC = 2'd3
   } status_type;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int USED_W = 3;
   localparam int ENC_W  = 3;

   localparam logic [CP_W-1:0]   MAX_CP      = 21'h10FFFF;
   localparam logic [31:0]       MAX_CP32    = 32'h0010FFFF;
   localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h010000;
   localparam logic [15:0]       SUR_FIRST   = 16'hD800;
   localparam logic [15:0]       SUR_LAST    = 16'hDFFF;
   localparam logic [15:0]       HI_SUR_LAST = 16'hDBFF;
   localparam logic [15:0]       LO_SUR_FIRST = 16'hDC00;

   localparam logic [USED_W-1:0] USED_NONE = 3'd0;
   localparam logic [USED_W-1:0] USED_ONE  = 3'd1;
   localparam logic [USED_W-1:0] USED_TWO  = 3'd2;
   localparam logic [USED_W-1:0] USED_THREE = 3'd3;
   localparam logic [USED_W-1:0] USED_FOUR = 3'd4;

endpackage

/* hw/rtl/ucpd_if.sv */
// ----------------------------------------------------------------------------
// ucpd channel interfaces
// valid/ready channels for the byte window, the decoded result and the
// encoding register write
// ----------------------------------------------------------------------------
interface ucpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ucpd_pkg::BYTE_W-1:0]  byte0;
   logic [ucpd_pkg::BYTE_W-1:0]  byte1;
   logic [ucpd_pkg::BYTE_W-1:0]  byte2;
   logic [ucpd_pkg::BYTE_W-1:0]  byte3;

   modport source (output valid, byte0, byte1, byte2, byte3, input ready);
   modport sink   (input valid, byte0, byte1, byte2, byte3, output ready);
endinterface

interface ucpd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ucpd_pkg::CP_W-1:0]    code_point;
   logic [ucpd_pkg::USED_W-1:0]  bytes_used;
   logic [1:0]                   status;

   modport source (output valid, code_point, bytes_used, status, input ready);
   modport sink   (input valid, code_point, bytes_used, status, output ready);
endinterface

interface ucpd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ucpd_pkg::ENC_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/unicode_code_point_decoder_top.sv */
// ----------------------------------------------------------------------------
// unicode_code_point_decoder_top
// decodes one code point per byte window in the configured encoding
// ----------------------------------------------------------------------------
// req carries a four-byte window that starts at a code point, byte0 first.
// rsp returns one result per window: code point, bytes used and status
// (ok, bad sequence, bad code point, unrecognized encoding); on any error
// the code point and byte count are zero.
// csr writes the 3-bit encoding register (0 ascii, 1 utf8, 2/3 utf16 be/le,
// 4/5 utf32 be/le); write it only while no window is in flight.
// pipeline: three register stages (byte order and lead byte class, value
// assembly and range checks, result select into the output register);
// each window is registered in all three before rsp valid rises for it.
// throughput: one window per cycle; each stage moves on whenever the stage
// after it is empty or moving, so req stays ready while rsp waits as long
// as a stage is free.
// when rsp stalls, results hold in place and up to three windows are
// buffered before req drops ready; nothing is lost or repeated.
// reset clears all stage valid bits and sets the encoding to utf8.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unicode_code_point_decoder_top (
   input  logic clock,
   input  logic reset,
   ucpd_req_if.sink   req,
   ucpd_rsp_if.source rsp,
   ucpd_csr_if.sink   csr
);
   import ucpd_pkg::*;

   // encoding register
   enc_type encoding_ff;

   // stage 1: byte order and utf-8 lead classification
   logic              s1_valid_ff;
   enc_type           s1_enc_ff;
   logic [7:0]        s1_b0_ff, s1_b1_ff, s1_b2_ff, s1_b3_ff;
   logic [15:0]       s1_w1_ff, s1_w2_ff;
   logic [31:0]       s1_v32_ff;
   logic [USED_W-1:0] s1_n8_ff;
   logic              s1_lead_ok_ff;
   logic [2:0]        s1_cont_ok_ff;
   logic [15:0]       s1_w1_in, s1_w2_in;
   logic [31:0]       s1_v32_in;
   logic [USED_W-1:0] s1_n8_in;
   logic              s1_lead_ok_in;
   logic [2:0]        s1_cont_ok_in;

   // stage 2: value assembly and range checks
   logic              s2_valid_ff;
   enc_type           s2_enc_ff;
   logic [7:0]        s2_b0_ff;
   logic [CP_W-1:0]   s2_v8_ff;
   logic [USED_W-1:0] s2_n8_ff;
   logic              s2_seq8_ok_ff;
   logic [15:0]       s2_w1_ff;
   logic              s2_w1_sur_ff;
   logic              s2_pair_ok_ff;
   logic [CP_W-1:0]   s2_v16p_ff;
   logic [CP_W-1:0]   s2_v32_ff;
   logic              s2_v32_ok_ff;
   logic [CP_W-1:0]   s2_v8_in;
   logic              s2_seq8_ok_in;
   logic              s2_w1_sur_in;
   logic              s2_pair_ok_in;
   logic [CP_W-1:0]   s2_v16p_in;
   logic              s2_v32_ok_in;

   // stage 3: output register
   logic              s3_valid_ff;
   enc_type           s3_enc_ff;
   logic [CP_W-1:0]   s3_cp_ff;
   logic [USED_W-1:0] s3_used_ff;
   status_type        s3_status_ff;
   logic [CP_W-1:0]   s3_cp_in;
   logic [USED_W-1:0] s3_used_in;
   status_type        s3_status_in;

   logic s1_ready, s2_ready, s3_ready;
   logic s3_cp_bad;

   // ---------------------------------------------------------------- control
   assign s3_ready  = !s3_valid_ff || rsp.ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff <= ENC_UTF8;
      end else if (csr.valid && csr.ready) begin
         encoding_ff <= enc_type'(csr.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      if (encoding_ff == ENC_UTF16LE) begin
         s1_w1_in = {req.byte1, req.byte0};
         s1_w2_in = {req.byte3, req.byte2};
      end else begin
         s1_w1_in = {req.byte0, req.byte1};
         s1_w2_in = {req.byte2, req.byte3};
      end
      if (encoding_ff == ENC_UTF32LE) begin
         s1_v32_in = {req.byte3, req.byte2, req.byte1, req.byte0};
      end else begin
         s1_v32_in = {req.byte0, req.byte1, req.byte2, req.byte3};
      end

      s1_lead_ok_in = 1'b1;
      priority casez (req.byte0)
         8'b0???????: s1_n8_in = USED_ONE;
         8'b110?????: s1_n8_in = USED_TWO;
         8'b1110????: s1_n8_in = USED_THREE;
         8'b11110???: s1_n8_in = USED_FOUR;
         default: begin
            s1_n8_in      = USED_NONE;
            s1_lead_ok_in = 1'b0;
         end
      endcase

      s1_cont_ok_in = {req.byte3[7:6] == 2'b10,
                       req.byte2[7:6] == 2'b10,
                       req.byte1[7:6] == 2'b10};
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req.valid) begin
         s1_enc_ff     <= encoding_ff;
         s1_b0_ff      <= req.byte0;
         s1_b1_ff      <= req.byte1;
         s1_b2_ff      <= req.byte2;
         s1_b3_ff      <= req.byte3;
         s1_w1_ff      <= s1_w1_in;
         s1_w2_ff      <= s1_w2_in;
         s1_v32_ff     <= s1_v32_in;
         s1_n8_ff      <= s1_n8_in;
         s1_lead_ok_ff <= s1_lead_ok_in;
         s1_cont_ok_ff <= s1_cont_ok_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      // only the continuation bytes that the lead byte calls for are checked
      unique case (s1_n8_ff)
         USED_TWO: begin
            s2_v8_in      = {10'd0, s1_b0_ff[4:0], s1_b1_ff[5:0]};
            s2_seq8_ok_in = s1_lead_ok_ff && s1_cont_ok_ff[0];
         end
         USED_THREE: begin
            s2_v8_in      = {5'd0, s1_b0_ff[3:0], s1_b1_ff[5:0], s1_b2_ff[5:0]};
            s2_seq8_ok_in = s1_lead_ok_ff && (&s1_cont_ok_ff[1:0]);
         end
         USED_FOUR: begin
            s2_v8_in      = {s1_b0_ff[2:0], s1_b1_ff[5:0], s1_b2_ff[5:0],
                             s1_b3_ff[5:0]};
            s2_seq8_ok_in = s1_lead_ok_ff && (&s1_cont_ok_ff);
         end
         default: begin
            s2_v8_in      = {14'd0, s1_b0_ff[6:0]};
            s2_seq8_ok_in = s1_lead_ok_ff;
         end
      endcase

      s2_w1_sur_in  = (s1_w1_ff >= SUR_FIRST) && (s1_w1_ff <= SUR_LAST);
      s2_pair_ok_in = (s1_w1_ff <= HI_SUR_LAST) && (s1_w2_ff >= LO_SUR_FIRST)
                      && (s1_w2_ff <= SUR_LAST);
      s2_v16p_in    = {1'b0, s1_w1_ff[9:0], s1_w2_ff[9:0]} + SUPP_BASE;
      s2_v32_ok_in  = (s1_v32_ff <= MAX_CP32)
                      && !((s1_v32_ff >= {16'd0, SUR_FIRST})
                           && (s1_v32_ff <= {16'd0, SUR_LAST}));
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_enc_ff     <= s1_enc_ff;
         s2_b0_ff      <= s1_b0_ff;
         s2_v8_ff      <= s2_v8_in;
         s2_n8_ff      <= s1_n8_ff;
         s2_seq8_ok_ff <= s2_seq8_ok_in;
         s2_w1_ff      <= s1_w1_ff;
         s2_w1_sur_ff  <= s2_w1_sur_in;
         s2_pair_ok_ff <= s2_pair_ok_in;
         s2_v16p_ff    <= s2_v16p_in;
         s2_v32_ff     <= s1_v32_ff[CP_W-1:0];
         s2_v32_ok_ff  <= s2_v32_ok_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   assign s3_cp_bad = (s2_v8_ff > MAX_CP)
                      || ((s2_v8_ff >= {5'd0, SUR_FIRST})
                          && (s2_v8_ff <= {5'd0, SUR_LAST}));

   always_comb begin
      s3_cp_in     = '0;
      s3_used_in   = USED_NONE;
      s3_status_in = ST_OK;
      unique case (s2_enc_ff)
         ENC_ASCII: begin
            s3_cp_in   = {13'd0, s2_b0_ff};
            s3_used_in = USED_ONE;
         end
         ENC_UTF8: begin
            if (!s2_seq8_ok_ff) begin
               s3_status_in = ST_BAD_SEQ;
            end else if (s3_cp_bad) begin
               s3_status_in = ST_BAD_CP;
            end else begin
               s3_cp_in   = s2_v8_ff;
               s3_used_in = s2_n8_ff;
            end
         end
         ENC_UTF16BE, ENC_UTF16LE: begin
            if (!s2_w1_sur_ff) begin
               s3_cp_in   = {5'd0, s2_w1_ff};
               s3_used_in = USED_TWO;
            end else if (s2_pair_ok_ff) begin
               s3_cp_in   = s2_v16p_ff;
               s3_used_in = USED_FOUR;
            end else begin
               s3_status_in = ST_BAD_SEQ;
            end
         end
         ENC_UTF32BE, ENC_UTF32LE: begin
            if (s2_v32_ok_ff) begin
               s3_cp_in   = s2_v32_ff;
               s3_used_in = USED_FOUR;
            end else begin
               s3_status_in = ST_BAD_CP;
            end
         end
         default: begin
            s3_status_in = ST_BAD_ENC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_enc_ff    <= s2_enc_ff;
         s3_cp_ff     <= s3_cp_in;
         s3_used_ff   <= s3_used_in;
         s3_status_ff <= s3_status_in;
      end
   end

   assign rsp.valid      = s3_valid_ff;
   assign rsp.code_point = s3_cp_ff;
   assign rsp.bytes_used = s3_used_ff;
   assign rsp.status     = s3_status_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_IMPLY(a_err_zero, clock, reset,
      rsp.valid && (s3_status_ff != ST_OK),
      (s3_cp_ff == '0) && (s3_used_ff == USED_NONE),
      "error result carries a nonzero code point or byte count")
   `ASSERT_IMPLY(a_ok_used, clock, reset,
      rsp.valid && (s3_status_ff == ST_OK),
      (s3_used_ff != USED_NONE) && (s3_used_ff <= USED_FOUR) && (s3_cp_ff <= MAX_CP),
      "ok result with bad byte count or code point")
   `ASSERT_IMPLY(a_ascii_pass, clock, reset,
      rsp.valid && (s3_enc_ff == ENC_ASCII),
      (s3_status_ff == ST_OK) && (s3_used_ff == USED_ONE) && (s3_cp_ff[CP_W-1:8] == '0),
      "ascii result is not a one-byte pass-through")
   `ASSERT_IMPLY(a_bad_enc, clock, reset,
      rsp.valid && (s3_status_ff == ST_BAD_ENC),
      (s3_enc_ff != ENC_ASCII) && (s3_enc_ff != ENC_UTF8) && (s3_enc_ff != ENC_UTF16BE)
         && (s3_enc_ff != ENC_UTF16LE) && (s3_enc_ff != ENC_UTF32BE)
         && (s3_enc_ff != ENC_UTF32LE),
      "unrecognized encoding status for a known encoding")

endmodule
